// File: rtl/mer_pkg.sv
package mer_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 11;

    // action codes of a request
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // order of the four symmetric pixels of one point
    localparam logic [1:0] PIX_PP = 2'd0;   // (+x, +y)
    localparam logic [1:0] PIX_MM = 2'd1;   // (-x, -y)
    localparam logic [1:0] PIX_PM = 2'd2;   // (+x, -y)
    localparam logic [1:0] PIX_MP = 2'd3;   // (-x, +y)

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ST_AA,
        OP_ST_BB,
        OP_ST_A2B,
        OP_ST_INIT,
        OP_R2_TX,
        OP_R2_TY,
        OP_R2_BT,
        OP_R2_AT,
        OP_R2_AB,
        OP_R2_SUM,
        OP_PIX,
        OP_R1_X,
        OP_R1_DN,
        OP_R1_Y,
        OP_R1_DY,
        OP_R2_Y,
        OP_R2_DP,
        OP_R2_X,
        OP_R2_DX
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] idx;
        logic       fin;
    } dp_cmd_t;

    typedef struct packed {
        logic fx_lt_fy;
        logic d_neg;
        logic d_pos;
        logic y_zero;
    } dp_status_t;

endpackage

// File: rtl/mer_in_if.sv
interface mer_in_if #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [COORD_BITS-1:0]  centre_x;
    logic [COORD_BITS-1:0]  centre_y;
    logic [RADIUS_BITS-1:0] radius_a;
    logic [RADIUS_BITS-1:0] radius_b;

    modport source (output valid, action, centre_x, centre_y, radius_a, radius_b,
                    input ready);
    modport sink (input valid, action, centre_x, centre_y, radius_a, radius_b,
                  output ready);
endinterface

// File: rtl/mer_out_if.sv
interface mer_out_if #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS+1:0] pixel_x;
    logic signed [COORD_BITS+1:0] pixel_y;
    logic                         last_of_point;
    logic                         final_point;

    modport source (output valid, pixel_x, pixel_y, last_of_point, final_point,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, last_of_point, final_point,
                  output ready);
endinterface

// File: rtl/mer_datapath.sv
module mer_datapath #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                          clk,
    input  mer_pkg::dp_cmd_t              cmd,
    input  logic [COORD_BITS-1:0]         centre_x,
    input  logic [COORD_BITS-1:0]         centre_y,
    input  logic [RADIUS_BITS-1:0]        radius_a,
    input  logic [RADIUS_BITS-1:0]        radius_b,
    output mer_pkg::dp_status_t           status,
    output logic signed [COORD_BITS+1:0]  pixel_x,
    output logic signed [COORD_BITS+1:0]  pixel_y,
    output logic                          last_of_point,
    output logic                          final_point
);
    import mer_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int RB = RADIUS_BITS;
    localparam int XW = RB + 1;
    localparam int YW = RB;
    localparam int SW = 2 * RB;
    localparam int DW = 4 * RB + 4;
    localparam int MW = 2 * RB + 3;
    localparam int OW = CB + 2;
    localparam int PW = ((CB > XW) ? CB : XW) + 2;

    logic [CB-1:0]        cx_reg, cy_reg;
    logic [RB-1:0]        ra_reg, rb_reg;
    logic [XW-1:0]        x_reg;
    logic [YW-1:0]        y_reg;
    logic signed [DW-1:0] d_reg, fx_reg, fy_reg, acc_reg;
    logic [SW-1:0]        a2_reg, b2_reg;
    logic [MW-1:0]        t1_reg, t2_reg;
    logic [DW-1:0]        prod_reg;
    logic signed [OW-1:0] px_reg, py_reg;
    logic                 last_reg, fin_reg;

    logic [MW-1:0]        mul_a, mul_b;
    logic [2*MW-1:0]      mul_p;
    logic [MW-1:0]        tx, ty_abs;
    logic signed [DW-1:0] a2_s, b2_s, prod_s;
    logic signed [PW-1:0] cx_s, cy_s, x_s, y_s, px_w, py_w;

    assign tx     = MW'({x_reg, 1'b1});
    assign ty_abs = (y_reg == '0) ? MW'(1) : MW'(y_reg - YW'(1));
    assign a2_s   = $signed(DW'(a2_reg));
    assign b2_s   = $signed(DW'(b2_reg));
    assign prod_s = $signed(prod_reg);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_ST_AA:
            begin
                mul_a = MW'(ra_reg);
                mul_b = MW'(ra_reg);
            end
            OP_ST_BB:
            begin
                mul_a = MW'(rb_reg);
                mul_b = MW'(rb_reg);
            end
            OP_ST_A2B:
            begin
                mul_a = MW'(a2_reg);
                mul_b = MW'(rb_reg);
            end
            OP_R2_TX:
            begin
                mul_a = tx;
                mul_b = tx;
            end
            OP_R2_TY:
            begin
                mul_a = ty_abs;
                mul_b = ty_abs;
            end
            OP_R2_BT:
            begin
                mul_a = MW'(b2_reg);
                mul_b = t1_reg;
            end
            OP_R2_AT:
            begin
                mul_a = MW'(a2_reg);
                mul_b = t2_reg;
            end
            OP_R2_AB:
            begin
                mul_a = MW'(a2_reg);
                mul_b = MW'(b2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // symmetric pixel for the requested quadrant
    assign cx_s = $signed(PW'(cx_reg));
    assign cy_s = $signed(PW'(cy_reg));
    assign x_s  = $signed(PW'(x_reg));
    assign y_s  = $signed(PW'(y_reg));

    always_comb
    begin
        px_w = cx_s + x_s;
        py_w = cy_s + y_s;
        case (cmd.idx)
            PIX_PP:
            begin
                px_w = cx_s + x_s;
                py_w = cy_s + y_s;
            end
            PIX_MM:
            begin
                px_w = cx_s - x_s;
                py_w = cy_s - y_s;
            end
            PIX_PM:
            begin
                px_w = cx_s + x_s;
                py_w = cy_s - y_s;
            end
            PIX_MP:
            begin
                px_w = cx_s - x_s;
                py_w = cy_s + y_s;
            end
            default:
            begin
                px_w = cx_s + x_s;
                py_w = cy_s + y_s;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p[DW-1:0];
        case (cmd.op)
            OP_LOAD:
            begin
                cx_reg <= centre_x;
                cy_reg <= centre_y;
                ra_reg <= radius_a;
                rb_reg <= radius_b;
            end
            OP_ST_BB:   a2_reg <= prod_reg[SW-1:0];
            OP_ST_A2B:  b2_reg <= prod_reg[SW-1:0];
            OP_ST_INIT:
            begin
                d_reg  <= (b2_s <<< 2) - (prod_s <<< 2) + a2_s;
                fy_reg <= prod_s <<< 1;
                fx_reg <= '0;
                x_reg  <= '0;
                y_reg  <= rb_reg;
            end
            OP_R2_TY:   t1_reg  <= prod_reg[MW-1:0];
            OP_R2_BT:   t2_reg  <= prod_reg[MW-1:0];
            OP_R2_AT:   acc_reg <= prod_s;
            OP_R2_AB:   acc_reg <= acc_reg + (prod_s <<< 2);
            OP_R2_SUM:  d_reg   <= acc_reg - (prod_s <<< 2);
            OP_PIX:
            begin
                px_reg   <= px_w[OW-1:0];
                py_reg   <= py_w[OW-1:0];
                last_reg <= (cmd.idx == PIX_MP);
                fin_reg  <= cmd.fin;
            end
            OP_R1_X, OP_R2_X:
            begin
                x_reg  <= x_reg + XW'(1);
                fx_reg <= fx_reg + (b2_s <<< 1);
            end
            OP_R1_DN:   d_reg <= d_reg + ((fx_reg + b2_s) <<< 2);
            OP_R1_Y, OP_R2_Y:
            begin
                y_reg  <= y_reg - YW'(1);
                fy_reg <= fy_reg - (a2_s <<< 1);
            end
            OP_R1_DY:   d_reg <= d_reg + ((fx_reg - fy_reg + b2_s) <<< 2);
            OP_R2_DP:   d_reg <= d_reg + ((a2_s - fy_reg) <<< 2);
            OP_R2_DX:   d_reg <= d_reg + ((fx_reg - fy_reg + a2_s) <<< 2);
            default:
            begin
            end
        endcase
    end

    assign status.fx_lt_fy = (fx_reg < fy_reg);
    assign status.d_neg    = (d_reg < 0);
    assign status.d_pos    = (d_reg > 0);
    assign status.y_zero   = (y_reg == '0);

    assign pixel_x       = px_reg;
    assign pixel_y       = py_reg;
    assign last_of_point = last_reg;
    assign final_point   = fin_reg;

endmodule

// File: rtl/mer_controller.sv
module mer_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_action,
    output logic                req_ready,
    output logic                pix_valid,
    input  logic                pix_ready,
    input  mer_pkg::dp_status_t status,
    output mer_pkg::dp_cmd_t    cmd
);
    import mer_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ST_AA,
        S_ST_BB,
        S_ST_A2B,
        S_ST_INIT,
        S_CHECK,
        S_R2_TX,
        S_R2_TY,
        S_R2_BT,
        S_R2_AT,
        S_R2_AB,
        S_R2_SUM,
        S_EMIT,
        S_R1_X,
        S_R1_D,
        S_R1_DY,
        S_R2_Y,
        S_R2_D,
        S_R2_DX
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_R1,
        PH_R2
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       fin_reg, fin_next;
    logic       req_fire;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign pix_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = idx_reg;
        cmd.fin    = fin_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_action == ACT_START)
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = S_ST_AA;
                    end
                    else if (phase_reg != PH_IDLE)
                    begin
                        cmd.op     = OP_PIX;
                        cmd.idx    = PIX_PP;
                        cmd.fin    = (phase_reg == PH_R2) && status.y_zero;
                        idx_next   = PIX_PP;
                        fin_next   = cmd.fin;
                        valid_next = 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end
            S_ST_AA:
            begin
                cmd.op     = OP_ST_AA;
                state_next = S_ST_BB;
            end
            S_ST_BB:
            begin
                cmd.op     = OP_ST_BB;
                state_next = S_ST_A2B;
            end
            S_ST_A2B:
            begin
                cmd.op     = OP_ST_A2B;
                state_next = S_ST_INIT;
            end
            S_ST_INIT:
            begin
                cmd.op     = OP_ST_INIT;
                phase_next = PH_R1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = status.fx_lt_fy ? S_IDLE : S_R2_TX;
            end
            S_R2_TX:
            begin
                cmd.op     = OP_R2_TX;
                state_next = S_R2_TY;
            end
            S_R2_TY:
            begin
                cmd.op     = OP_R2_TY;
                state_next = S_R2_BT;
            end
            S_R2_BT:
            begin
                cmd.op     = OP_R2_BT;
                state_next = S_R2_AT;
            end
            S_R2_AT:
            begin
                cmd.op     = OP_R2_AT;
                state_next = S_R2_AB;
            end
            S_R2_AB:
            begin
                cmd.op     = OP_R2_AB;
                state_next = S_R2_SUM;
            end
            S_R2_SUM:
            begin
                cmd.op     = OP_R2_SUM;
                phase_next = PH_R2;
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (pix_ready)
                begin
                    if (idx_reg == PIX_MP)
                    begin
                        valid_next = 1'b0;
                        if (fin_reg)
                        begin
                            phase_next = PH_IDLE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = (phase_reg == PH_R1) ? S_R1_X : S_R2_Y;
                        end
                    end
                    else
                    begin
                        cmd.op   = OP_PIX;
                        cmd.idx  = idx_reg + 2'd1;
                        idx_next = cmd.idx;
                    end
                end
            end
            S_R1_X:
            begin
                cmd.op     = OP_R1_X;
                state_next = S_R1_D;
            end
            S_R1_D:
            begin
                if (status.d_neg)
                begin
                    cmd.op     = OP_R1_DN;
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.op     = OP_R1_Y;
                    state_next = S_R1_DY;
                end
            end
            S_R1_DY:
            begin
                cmd.op     = OP_R1_DY;
                state_next = S_CHECK;
            end
            S_R2_Y:
            begin
                cmd.op     = OP_R2_Y;
                state_next = S_R2_D;
            end
            S_R2_D:
            begin
                if (status.d_pos)
                begin
                    cmd.op     = OP_R2_DP;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_R2_X;
                    state_next = S_R2_DX;
                end
            end
            S_R2_DX:
            begin
                cmd.op     = OP_R2_DX;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= PIX_PP;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// File: rtl/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer. A request with action 0 loads a centre and two
// semi-axes and sets up the first region of the arc; it produces no pixels.
// Each request with action 1 produces the four symmetric pixels of the
// current point, in the order (+x,+y), (-x,-y), (+x,-y), (-x,+y), one per
// cycle on the pixel channel while it is ready, and then advances to the
// next point. The fourth pixel of each point carries last_of_point; all
// four pixels of the y = 0 point carry final_point, after which steps
// produce nothing until the next start. Coordinates are unclipped two's
// complement. A start runs the four-step multiply sequence on the single
// shared multiplier before the next request is taken, and then also the
// multiply sequence that seeds the second region when the first is empty.
// After its pixels a step updates the decision term, and in the first
// region tests for the region change; the step that crosses into the
// second region also runs the multiply sequence that seeds its decision
// term. The final step ends after its pixels. Requests are taken only
// while the block is between items.
module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    mer_in_if.sink     request,
    mer_out_if.source  pixel
);
    import mer_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing: handshakes, region phase and the step order of each operation
    mer_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (request.valid),
        .req_action (request.action),
        .req_ready  (request.ready),
        .pix_valid  (pixel.valid),
        .pix_ready  (pixel.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // arithmetic: point, decision term, slope terms and the pixel register
    mer_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .centre_x      (request.centre_x),
        .centre_y      (request.centre_y),
        .radius_a      (request.radius_a),
        .radius_b      (request.radius_b),
        .status        (status),
        .pixel_x       (pixel.pixel_x),
        .pixel_y       (pixel.pixel_y),
        .last_of_point (pixel.last_of_point),
        .final_point   (pixel.final_point)
    );

endmodule
